### rtl/core/pat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional array table.
// Used by pat_ctrl, positional_array_table and the testbench; no dependencies.
package pat_pkg;

	localparam int WORD_W    = 32;
	localparam int CMD_W     = 3;
	localparam int POS_W     = 8;
	localparam int CNT_W     = 7;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_DISPLAY = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_SEARCH  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		status_t                  status;
		logic signed [WORD_W-1:0] element;
		logic [CNT_W-1:0]         found_pos;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} res_t;

endpackage

### rtl/core/pat_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/pat_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer (needs pat_pkg): walks the element RAM one entry a cycle,
// pausing display on res_ready, via one index adder and one word comparator.
module pat_ctrl import pat_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     busy,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] insert_value,
	input  logic signed [WORD_W-1:0] search_key,
	input  logic                     res_ready,
	output logic                     res_valid,
	output res_t                     res,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic [WORD_W-1:0]        ram_wdata,
	output logic                     ram_re,
	output logic [AW-1:0]            ram_raddr,
	input  logic [WORD_W-1:0]        ram_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_INS,
		S_PUT,
		S_DEL,
		S_SRCH,
		S_RES
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] wa_q;
	logic [CNT_W-1:0] tgt_q;
	logic             pend_q;
	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] key_q;
	status_t          status_q;
	logic [CNT_W-1:0] fpos_q;

	logic [CNT_W-1:0] idx_nxt;
	logic             hit;
	logic             disp_last;
	logic [POS_W-1:0] pos_m1;
	logic [POS_W-1:0] cnt_p1;
	logic             full;

	// The one index adder: steps down while opening a gap, up otherwise.
	assign idx_nxt   = idx_q + ((state_q == S_INS) ? {CNT_W{1'b1}} : CNT_W'(1));
	assign hit       = pend_q && (ram_rdata == key_q);
	assign disp_last = (idx_nxt == cnt_q);
	assign pos_m1    = position - POS_W'(1);
	assign cnt_p1    = POS_W'(cnt_q) + POS_W'(1);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (req_valid && cmd == CMD_DISPLAY && cnt_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
				end
			end
			S_DISP: begin
				if (res_ready && !disp_last) begin
					ram_re    = 1'b1;
					ram_raddr = idx_nxt[AW-1:0];
				end
			end
			S_INS: begin
				ram_we = pend_q;
				if (idx_q > tgt_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_nxt[AW-1:0];
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q[AW-1:0];
				ram_wdata = val_q;
			end
			S_DEL: begin
				ram_we = pend_q;
				if (idx_nxt < cnt_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_nxt[AW-1:0];
				end
			end
			S_SRCH: begin
				if (!hit && idx_q < cnt_q) begin
					ram_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_valid     = 1'b0;
		res.status    = status_q;
		res.element   = '0;
		res.found_pos = fpos_q;
		res.count     = cnt_q;
		res.last      = 1'b1;
		case (state_q)
			S_DISP: begin
				res_valid     = 1'b1;
				res.status    = ST_OK;
				res.element   = ram_rdata;
				res.found_pos = '0;
				res.last      = disp_last;
			end
			S_RES: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			wa_q     <= '0;
			tgt_q    <= '0;
			pend_q   <= 1'b0;
			val_q    <= '0;
			key_q    <= '0;
			status_q <= ST_OK;
			fpos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						status_q <= ST_OK;
						fpos_q   <= '0;
						pend_q   <= 1'b0;
						state_q  <= S_RES;
						case (cmd)
							CMD_CLEAR: begin
								cnt_q <= '0;
							end
							CMD_DISPLAY: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= S_DISP;
								end
							end
							CMD_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (position == '0 || position > cnt_p1) begin
									status_q <= ST_BADPOS;
								end else begin
									tgt_q   <= pos_m1[CNT_W-1:0];
									idx_q   <= cnt_q;
									val_q   <= insert_value;
									state_q <= S_INS;
								end
							end
							CMD_DELETE: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else if (position == '0 || position > POS_W'(cnt_q)) begin
									status_q <= ST_BADPOS;
								end else begin
									idx_q   <= pos_m1[CNT_W-1:0];
									state_q <= S_DEL;
								end
							end
							CMD_SEARCH: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									idx_q   <= '0;
									key_q   <= search_key;
									state_q <= S_SRCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DISP: begin
					if (res_ready) begin
						if (disp_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_nxt;
						end
					end
				end
				S_INS: begin
					if (idx_q > tgt_q) begin
						pend_q <= 1'b1;
						wa_q   <= idx_q;
						idx_q  <= idx_nxt;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_PUT;
						end
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_RES;
				end
				S_DEL: begin
					if (idx_nxt < cnt_q) begin
						pend_q <= 1'b1;
						wa_q   <= idx_q;
						idx_q  <= idx_nxt;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= S_RES;
						end
					end
				end
				S_SRCH: begin
					if (hit) begin
						fpos_q  <= wa_q;
						state_q <= S_RES;
					end else if (idx_q < cnt_q) begin
						pend_q <= 1'b1;
						wa_q   <= idx_nxt;
						idx_q  <= idx_nxt;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_RES;
						end
					end
				end
				S_RES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/positional_array_table.sv
`timescale 1ns / 1ps
// Positional array table: a packed table of signed words in a single RAM,
// edited and read by a one-entry-a-cycle sequencer.
// Depends on pat_pkg, pat_ram and pat_ctrl.
//
// Usage. Each request on the input channel (in_valid / in_stall) carries one
// command: clear, display, insert, delete or search, with a 1-based position,
// an insert value and a search key. Results leave on the output channel
// (out_valid / out_stall) from an output register; display gives one result
// per held element with last set on the final one (a single result on an
// empty table), every other command gives a single result with last set.
// Each result reports a status and the count held after the command.
// Timing. in_stall is high from the edge that accepts a request until its
// final result is loaded into the output register, so one request is worked
// at a time. The sequencer reads or writes one RAM entry per cycle through a
// single read and a single write port. A display reads the held elements in
// order; a search compares from the first entry until a match or the end;
// insert moves each entry from the last down to the position one place back,
// then writes the value; delete moves each entry after the position one place
// forward; clear, an empty table, a rejected position or a spare code go
// straight to the result. A waiting result does not stop the next request
// being taken once the sequencer is free.
// Reset. arst_n clears the count, the sequencer and the output valid flag at
// once; the RAM needs no clearing pass as only written entries are ever read.
// Stall. While out_stall holds a result in the output register, the sequencer
// waits at its next result, and a display walk simply pauses on the current
// element; the shifting and comparing walks run on regardless.
module positional_array_table import pat_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] insert_value,
	input  logic signed [WORD_W-1:0] search_key,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic signed [WORD_W-1:0] element,
	output logic [CNT_W-1:0]         found_position,
	output logic [CNT_W-1:0]         count,
	output logic                     last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              busy;
	logic              res_ready;
	logic              res_valid;
	res_t              res;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic out_valid_q;
	res_t out_q;

	// The sequencer only takes a request while it is idle.
	assign in_stall = busy;

	// A result may be loaded when the output register is empty or being drained.
	assign res_ready = !out_valid_q || !out_stall;

	pat_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (in_valid),
		.busy         (busy),
		.cmd          (cmd),
		.position     (position),
		.insert_value (insert_value),
		.search_key   (search_key),
		.res_ready    (res_ready),
		.res_valid    (res_valid),
		.res          (res),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	pat_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: the payload needs no reset, only the valid flag does.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign element        = out_q.element;
	assign found_position = out_q.found_pos;
	assign count          = out_q.count;
	assign last           = out_q.last;

	// An accepted request always keeps the sequencer busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer free straight after taking a request");

	// The table never holds more than DEPTH entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= CNT_W'(DEPTH)))
		else $error("count beyond table depth");

	// Only a display walk gives a result without last, and never on an empty table.
	a_mid_display: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == ST_OK && count != '0))
		else $error("non-final result outside a display walk");

	// A found position is a held position of a successful search.
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found_position != '0) |-> (status == ST_OK && found_position <= count))
		else $error("found position outside the table");

endmodule

### tb/tb_positional_array_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_array_table: a queue-fed driver, a shadow table that
// predicts every result, and a monitor that checks each result against the oldest prediction.
// Depends on pat_pkg and the positional_array_table RTL only.
module tb_positional_array_table;
	import pat_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_REQUESTS = 300;
	localparam int TAIL_CYCLES = 80;
	localparam int REPORT_LIMIT = 10;

	// Command codes that the block treats as no-ops; the package has no names for them.
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

	// One request as queued for the driver. The hold flag makes the driver wait until every
	// result owed so far has been checked before it offers this request.
	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
		logic signed [WORD_W-1:0] key;
		logic                     hold;
	} table_req_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         cmd = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [WORD_W-1:0] insert_value = '0;
	logic signed [WORD_W-1:0] search_key = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [2:0]               status;
	logic signed [WORD_W-1:0] element;
	logic [CNT_W-1:0]         found_position;
	logic [CNT_W-1:0]         count;
	logic                     last;

	positional_array_table #(.DEPTH(TABLE_DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.position      (position),
		.insert_value  (insert_value),
		.search_key    (search_key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.element       (element),
		.found_position(found_position),
		.count         (count),
		.last          (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Requests waiting to be offered, and results owed by requests already taken.
	table_req_t command_queue[$];
	res_t       table_replies[$];

	// Shadow copy of the table, updated as each request is accepted.
	logic signed [WORD_W-1:0] shadow_words [0:TABLE_DEPTH-1];
	int shadow_count = 0;
	int shadow_peak = 0;
	int full_rejects = 0;

	// Book-keeping shared between the processes. The accept, result and cycle counters are
	// written with nonblocking assignments so that every reader sees the value before the edge.
	int  reqs_planned = 0;
	int  reqs_accepted = 0;
	int  replies_made = 0;
	int  replies_seen = 0;
	int  fault_count = 0;
	int  cycle_count = 0;
	int  plan_count = 0;
	bit  hold_next = 1'b0;

	function automatic res_t make_reply(input status_t st, input logic signed [WORD_W-1:0] word,
			input int fpos, input int cnt, input logic fin);
		res_t r;
		r.status    = st;
		r.element   = word;
		r.found_pos = fpos[CNT_W-1:0];
		r.count     = cnt[CNT_W-1:0];
		r.last      = fin;
		return r;
	endfunction

	// Applies one accepted request to the shadow table and queues the results that it owes.
	// Fullness is judged before the position on insert, and emptiness before the position on
	// delete, exactly as the block is specified to do.
	task automatic table_apply(input table_req_t rq, output int made);
		int n;
		int p;
		int i;
		bit hit;
		n = shadow_count;
		p = rq.position;
		made = 1;
		case (rq.cmd)
			CMD_CLEAR: begin
				shadow_count = 0;
				table_replies.push_back(make_reply(ST_OK, '0, 0, 0, 1'b1));
			end
			CMD_DISPLAY: begin
				if (n == 0) begin
					table_replies.push_back(make_reply(ST_EMPTY, '0, 0, 0, 1'b1));
				end else begin
					for (i = 0; i < n; i++)
						table_replies.push_back(make_reply(ST_OK, shadow_words[i], 0, n,
							i + 1 == n));
					made = n;
				end
			end
			CMD_INSERT: begin
				if (n >= TABLE_DEPTH) begin
					full_rejects++;
					table_replies.push_back(make_reply(ST_FULL, '0, 0, n, 1'b1));
				end else if (p < 1 || p > n + 1) begin
					table_replies.push_back(make_reply(ST_BADPOS, '0, 0, n, 1'b1));
				end else begin
					for (i = n; i >= p; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[p-1] = rq.value;
					shadow_count = n + 1;
					if (shadow_count > shadow_peak)
						shadow_peak = shadow_count;
					table_replies.push_back(make_reply(ST_OK, '0, 0, n + 1, 1'b1));
				end
			end
			CMD_DELETE: begin
				if (n == 0) begin
					table_replies.push_back(make_reply(ST_EMPTY, '0, 0, 0, 1'b1));
				end else if (p < 1 || p > n) begin
					table_replies.push_back(make_reply(ST_BADPOS, '0, 0, n, 1'b1));
				end else begin
					for (i = p - 1; i + 1 < n; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_count = n - 1;
					table_replies.push_back(make_reply(ST_OK, '0, 0, n - 1, 1'b1));
				end
			end
			CMD_SEARCH: begin
				if (n == 0) begin
					table_replies.push_back(make_reply(ST_EMPTY, '0, 0, 0, 1'b1));
				end else begin
					hit = 1'b0;
					for (i = 0; i < n && !hit; i++) begin
						if (shadow_words[i] == rq.key) begin
							hit = 1'b1;
							table_replies.push_back(make_reply(ST_OK, '0, i + 1, n, 1'b1));
						end
					end
					if (!hit)
						table_replies.push_back(make_reply(ST_NOTFOUND, '0, 0, n, 1'b1));
				end
			end
			default: begin
				// Spare command codes leave the table untouched and still answer once.
				table_replies.push_back(make_reply(ST_OK, '0, 0, n, 1'b1));
			end
		endcase
	endtask

	// Queues one request and follows the count that it will leave behind, so that the
	// generator can aim positions at the valid range without knowing the contents.
	task automatic plan(input logic [CMD_W-1:0] c, input int p,
			input logic signed [WORD_W-1:0] v, input logic signed [WORD_W-1:0] k);
		table_req_t rq;
		rq.cmd      = c;
		rq.position = p[POS_W-1:0];
		rq.value    = v;
		rq.key      = k;
		rq.hold     = hold_next;
		hold_next   = 1'b0;
		command_queue.push_back(rq);
		reqs_planned++;
		case (c)
			CMD_CLEAR: plan_count = 0;
			CMD_INSERT: if (plan_count < TABLE_DEPTH && p >= 1 && p <= plan_count + 1)
				plan_count++;
			CMD_DELETE: if (plan_count > 0 && p >= 1 && p <= plan_count)
				plan_count--;
			default: ;
		endcase
	endtask

	// Words are drawn partly from a tiny pool so that duplicates and search hits are common,
	// partly from the extremes, and otherwise across all 32 bits.
	function automatic logic signed [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return int'($urandom_range(0, 8)) - 4;
		if (r < 45) begin
			case ($urandom_range(0, 3))
				0: return WORD_MIN;
				1: return WORD_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// A position outside the valid range of both insert and delete at the current count.
	function automatic int pick_bad_position();
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(plan_count + 2, 255);
	endfunction

	// Builds the table up to its full depth, pushes against the limit, reads it back,
	// searches it and then trims it again.
	task automatic plan_fill_session();
		int i;
		plan(CMD_CLEAR, $urandom_range(0, 255), $urandom, $urandom);
		while (plan_count < TABLE_DEPTH)
			plan(CMD_INSERT, $urandom_range(1, plan_count + 1), pick_word(), $urandom);
		plan(CMD_INSERT, $urandom_range(1, plan_count + 1), pick_word(), $urandom);
		plan(CMD_INSERT, $urandom_range(0, 255), pick_word(), $urandom);
		plan(CMD_DISPLAY, $urandom_range(0, 255), $urandom, $urandom);
		plan(CMD_SEARCH, $urandom_range(0, 255), $urandom, pick_word());
		plan(CMD_SEARCH, $urandom_range(0, 255), $urandom, $urandom);
		plan(CMD_DELETE, TABLE_DEPTH, $urandom, $urandom);
		plan(CMD_DELETE, 1, $urandom, $urandom);
		for (i = 0; i < 3; i++)
			plan(CMD_DELETE, $urandom_range(1, plan_count), $urandom, $urandom);
		plan(CMD_CLEAR, $urandom_range(0, 255), $urandom, $urandom);
	endtask

	// Mostly well-formed editing of a small table, with some rejected positions and spare codes.
	task automatic plan_mixed_session();
		int len;
		int r;
		len = $urandom_range(8, 30);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				if (plan_count < 16)
					plan(CMD_INSERT, $urandom_range(1, plan_count + 1), pick_word(), $urandom);
				else
					plan(CMD_DELETE, $urandom_range(1, plan_count), $urandom, $urandom);
			end else if (r < 58) begin
				if (plan_count > 0)
					plan(CMD_DELETE, $urandom_range(1, plan_count), $urandom, $urandom);
				else
					plan(CMD_INSERT, 1, pick_word(), $urandom);
			end else if (r < 72) begin
				plan(CMD_SEARCH, $urandom_range(0, 255), $urandom, pick_word());
			end else if (r < 80) begin
				plan(CMD_DISPLAY, $urandom_range(0, 255), $urandom, $urandom);
			end else if (r < 84) begin
				plan(CMD_CLEAR, $urandom_range(0, 255), $urandom, $urandom);
			end else if (r < 93) begin
				plan($urandom_range(0, 1) ? CMD_INSERT : CMD_DELETE, pick_bad_position(),
					pick_word(), $urandom);
			end else begin
				plan(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
					$urandom_range(0, 255), $urandom, $urandom);
			end
		end
	endtask

	// Requests with every field drawn at random, spare codes included.
	task automatic plan_noise_session();
		repeat ($urandom_range(5, 15))
			plan(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 255), pick_word(),
				pick_word());
	endtask

	// Sender. A request stays on the pins until it is accepted; a new one is offered only
	// when the channel is free or the current one has just been taken. Gaps come between
	// bursts of random length, and a request marked hold waits until all owed results are in.
	// Its results are predicted at the edge that accepts it.
	int burst_left = 1;
	int gap_left = 0;
	table_req_t live_req;

	always @(posedge clk) begin
		bit took;
		int made;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				table_apply(live_req, made);
				replies_made  <= replies_made + made;
				reqs_accepted <= reqs_accepted + 1;
			end
			if (!in_valid || took) begin
				// After an acceptance the owed count is not yet visible, so a held request
				// is never offered at the edge that accepts the previous one.
				if (command_queue.size() != 0 && gap_left == 0 &&
						!(command_queue[0].hold && (took || replies_made != replies_seen))) begin
					live_req = command_queue.pop_front();
					cmd          <= live_req.cmd;
					position     <= live_req.position;
					insert_value <= live_req.value;
					search_key   <= live_req.key;
					in_valid     <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// Receiver. It alternates between quiet stretches with no stall at all and busy
	// stretches in which stalls start at random.
	int  stall_run = 0;
	int  stall_phase_left = 100;
	bit  stall_busy = 1'b1;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_phase_left > 0) begin
				stall_phase_left--;
			end else begin
				stall_busy = $urandom_range(0, 2) != 0;
				stall_phase_left = $urandom_range(50, 300);
			end
			if (stall_run > 0) begin
				stall_run--;
				out_stall <= 1'b1;
			end else if (stall_busy && $urandom_range(0, 99) < 30) begin
				stall_run = $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor. Every accepted result is checked field by field against the oldest one owed.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (table_replies.size() == 0) begin
				fault_count = fault_count + 1;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: status %0d element %0d found %0d count %0d last %0d",
						status, element, found_position, count, last);
			end else begin
				want = table_replies.pop_front();
				replies_seen <= replies_seen + 1;
				if (want.status != status || want.element != element ||
						want.found_pos != found_position || want.count != count ||
						want.last != last) begin
					fault_count = fault_count + 1;
					if (fault_count <= REPORT_LIMIT) begin
						$display("mismatch on result %0d:", replies_seen);
						$display("  expected status %0d element %0d found %0d count %0d last %0d",
							want.status, want.element, want.found_pos, want.count, want.last);
						$display("  got      status %0d element %0d found %0d count %0d last %0d",
							status, element, found_position, count, last);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d requests taken, %0d results owed",
				cycle_count, reqs_accepted, reqs_planned, table_replies.size());
			$display("tb_positional_array_table: FAIL");
			$finish;
		end
	end

	initial begin
		int directed_total;

		// Directed requests: the empty table, rejected positions on both sides of the valid
		// range, inserts at the front, middle and end with the extreme words, searches that hit
		// and miss, the spare command codes, and deletes at both ends.
		plan(CMD_DISPLAY, 0, '0, '0);
		plan(CMD_DELETE, 1, '0, '0);
		plan(CMD_SEARCH, 0, '0, '0);
		plan(CMD_INSERT, 0, 32'sd5, '0);
		plan(CMD_INSERT, 2, 32'sd5, '0);
		plan(CMD_INSERT, 1, WORD_MIN, '0);
		plan(CMD_INSERT, 2, WORD_MAX, '0);
		plan(CMD_INSERT, 1, -1, '0);
		plan(CMD_INSERT, 2, '0, '0);
		plan(CMD_DISPLAY, 8'hFF, '1, '1);
		plan(CMD_SEARCH, 0, '0, WORD_MAX);
		plan(CMD_SEARCH, 0, '0, 32'sd12345);
		plan(CMD_SEARCH, 0, '0, WORD_MIN);
		plan(CMD_DELETE, 0, '0, '0);
		plan(CMD_DELETE, 5, '0, '0);
		plan(CMD_INSERT, 255, '1, '1);
		plan(CMD_INSERT, 6, '1, '1);
		plan(CMD_SPARE_FIRST, 1, '1, '1);
		plan(CMD_SPARE_MID, 2, '0, '0);
		plan(CMD_SPARE_LAST, 255, WORD_MIN, WORD_MAX);
		plan(CMD_DELETE, 4, '0, '0);
		plan(CMD_DELETE, 1, '0, '0);
		plan(CMD_DISPLAY, 0, '0, '0);
		plan(CMD_CLEAR, 8'hAA, WORD_MAX, WORD_MIN);
		plan(CMD_DISPLAY, 0, '0, '0);
		directed_total = reqs_planned;

		// Random part. It opens with a pause for all owed results and one full build of the
		// table; later sessions mix small-table editing, noise and the odd further build.
		hold_next = 1'b1;
		plan_fill_session();
		while (reqs_planned - directed_total < RANDOM_REQUESTS) begin
			hold_next = $urandom_range(0, 3) == 0;
			case ($urandom_range(0, 11))
				0: plan_fill_session();
				1, 2: plan_noise_session();
				default: plan_mixed_session();
			endcase
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (reqs_accepted != reqs_planned)
			@(posedge clk);
		while (replies_made != replies_seen)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (table_replies.size() != 0) begin
			fault_count = fault_count + 1;
			$display("%0d results still owed at the end", table_replies.size());
		end

		$display("Ran %0d requests (%0d directed) and checked %0d results in %0d cycles.",
			reqs_accepted, directed_total, replies_seen, cycle_count);
		$display("Table peaked at %0d of %0d entries; %0d inserts refused as full; %0d faults.",
			shadow_peak, TABLE_DEPTH, full_rejects, fault_count);
		if (fault_count == 0)
			$display("tb_positional_array_table: PASS");
		else
			$display("tb_positional_array_table: FAIL");
		$finish;
	end

endmodule

### positional_array_table.f
rtl/core/pat_pkg.sv
rtl/core/pat_ram.sv
rtl/core/pat_ctrl.sv
rtl/core/positional_array_table.sv
tb/tb_positional_array_table.sv
